@@ rtl/assert_macros.svh @@
// Assertion macros for the load balancer RTL; wlb_ctrl includes them.
// Every macro expects signals named clk and rst in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define WLB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wlb: assertion failed");

// next-cycle implication
`define WLB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wlb: assertion failed");

`endif

@@ rtl/wlb_pkg.sv @@
// Package for the worker load balancer: sizes, codes and the structs
// passed between the controller and the cell chain. No dependencies.
package wlb_pkg;

  localparam int MAX_SLOTS   = 16;
  localparam int SLOT_W      = $clog2(MAX_SLOTS);
  localparam int CNT_W       = $clog2(MAX_SLOTS + 1);
  localparam int LOAD_W      = 16;
  localparam int OP_W        = 2;
  localparam int SLOT_FLD_W  = 4;
  localparam int STATUS_W    = 3;
  localparam int LIMIT_W     = 16;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;

  localparam logic [LOAD_W-1:0]  LOAD_MAX     = 16'hFFFF;
  localparam logic [LIMIT_W-1:0] DEFAULT_POOL = 16'd10;
  localparam logic [LIMIT_W-1:0] DEFAULT_CAP  = 16'd1000;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 16'd10;

  localparam logic MODE_FIXED = 1'b0;
  localparam logic MODE_GROW  = 1'b1;

  // register select bit (byte address bit 2)
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CLEAR   = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK      = 3'd0,
    STS_FULL    = 3'd1,
    STS_UNKNOWN = 3'd2,
    STS_RETIRED = 3'd3,
    STS_ZERO    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUILD,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_BUILD,
    CMD_CLEAR,
    CMD_WRITE
  } cmd_kind_t;

  // partial result carried down the chain
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
    logic [LOAD_W-1:0] load;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic [CNT_W-1:0]  cnt;
    logic              tgt_active;
    logic [LOAD_W-1:0] tgt_load;
  } scan_t;

  // broadcast to all cells; stable while a request is worked on only if the user does not write mode or limit then
  typedef struct packed {
    logic               mode;
    logic [LIMIT_W-1:0] cap;
    logic [LIMIT_W-1:0] pool_n;
    logic [SLOT_W-1:0]  tgt;
  } ctl_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [SLOT_W-1:0] idx;
    logic [LOAD_W-1:0] load;
    logic              active;
  } cmd_t;

endpackage

@@ rtl/wlb_if.sv @@
// Request and response channel interfaces of the load balancer.
// Depends on wlb_pkg.
interface wlb_req_if;
  import wlb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       op;
  logic [SLOT_FLD_W-1:0] slot;

  modport source (output valid, output op, output slot, input ready);
  modport sink   (input valid, input op, input slot, output ready);
endinterface

interface wlb_rsp_if;
  import wlb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [SLOT_FLD_W-1:0] granted_slot;
  logic [STATUS_W-1:0]   status;
  logic [LOAD_W-1:0]     load;

  modport source (output valid, output granted_slot, output status, output load,
                  input ready);
  modport sink   (input valid, input granted_slot, input status, input load,
                  output ready);
endinterface

@@ rtl/wlb_cell.sv @@
// One slot cell: holds the slot's load and active flag, folds itself
// into the scan record from its left neighbor. Depends on wlb_pkg.
module wlb_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [wlb_pkg::SLOT_W-1:0] idx,
  input  wlb_pkg::ctl_t             ctl,
  input  wlb_pkg::cmd_t             cmd,
  input  wlb_pkg::scan_t            scan_in,
  output wlb_pkg::scan_t            scan_out
);
  import wlb_pkg::*;

  logic [LOAD_W-1:0] load;
  logic              active;
  scan_t             scan_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else begin
      case (cmd.kind)
        CMD_BUILD: begin
          load <= '0;
          if (ctl.mode == MODE_FIXED) begin
            active <= (32'(idx) < 32'(ctl.pool_n));
          end else begin
            active <= (idx == '0);
          end
        end
        CMD_CLEAR: begin
          load <= '0;
        end
        CMD_WRITE: begin
          if (cmd.idx == idx) begin
            load   <= cmd.load;
            active <= cmd.active;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    scan_next = scan_in;
    if (ctl.mode == MODE_FIXED) begin
      if (active && (!scan_in.found || load < scan_in.load)) begin
        scan_next.found = 1'b1;
        scan_next.idx   = idx;
        scan_next.load  = load;
      end
    end else begin
      if (active && !scan_in.found && load < ctl.cap) begin
        scan_next.found = 1'b1;
        scan_next.idx   = idx;
        scan_next.load  = load;
      end
    end
    if (!active && !scan_in.free_found) begin
      scan_next.free_found = 1'b1;
      scan_next.free_idx   = idx;
    end
    if (active) begin
      scan_next.cnt = scan_in.cnt + CNT_W'(1);
    end
    if (idx == ctl.tgt) begin
      scan_next.tgt_active = active;
      scan_next.tgt_load   = load;
    end
  end

  always_ff @(posedge clk) begin
    scan_out <= scan_next;
  end

endmodule

@@ rtl/wlb_ctrl.sv @@
// Sequencer: takes a request, builds the pool on first use, waits for the
// scan wave to cross the chain, decides and writes back. Depends on wlb_pkg,
// wlb_if and assert_macros.svh.
module wlb_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        mode,
  input  logic [wlb_pkg::LIMIT_W-1:0] limit,
  wlb_req_if.sink                     req,
  wlb_rsp_if.source                   rsp,
  input  wlb_pkg::scan_t              scan_res,
  output wlb_pkg::ctl_t               ctl,
  output wlb_pkg::cmd_t               cmd
);
  import wlb_pkg::*;
  `include "assert_macros.svh"

  state_t                state, state_next;
  logic [SLOT_W-1:0]     cnt, cnt_next;
  op_t                   op_q;
  logic [SLOT_FLD_W-1:0] slot_q;
  logic                  pool_ready;
  logic                  rsp_valid;
  logic [SLOT_FLD_W-1:0] rsp_slot;
  status_t               rsp_status;
  logic [LOAD_W-1:0]     rsp_load;

  logic                  fire;
  logic                  slot_ok;
  logic [LOAD_W-1:0]     rel_load;
  cmd_t                  wcmd;
  logic [SLOT_FLD_W-1:0] res_slot;
  status_t               res_status;
  logic [LOAD_W-1:0]     res_load;

  assign ctl.mode   = mode;
  assign ctl.cap    = (limit == '0) ? DEFAULT_CAP : limit;
  assign ctl.pool_n = (limit == '0) ? DEFAULT_POOL : limit;
  assign ctl.tgt    = SLOT_W'(slot_q);

  assign req.ready        = (state == ST_IDLE);
  assign rsp.valid        = rsp_valid;
  assign rsp.granted_slot = rsp_slot;
  assign rsp.status       = rsp_status;
  assign rsp.load         = rsp_load;

  assign slot_ok  = (32'(slot_q) < MAX_SLOTS);
  assign rel_load = scan_res.tgt_load - LOAD_W'(1);

  // decision from the finished scan
  always_comb begin
    wcmd.kind   = CMD_NONE;
    wcmd.idx    = scan_res.idx;
    wcmd.load   = scan_res.load + LOAD_W'(1);
    wcmd.active = 1'b1;
    res_slot    = '0;
    res_status  = STS_OK;
    res_load    = '0;
    case (op_q)
      OP_ACQUIRE: begin
        if (mode == MODE_FIXED) begin
          if (!scan_res.found || scan_res.load == LOAD_MAX) begin
            res_status = STS_FULL;
          end else begin
            wcmd.kind = CMD_WRITE;
            res_slot  = SLOT_FLD_W'(scan_res.idx);
            res_load  = wcmd.load;
          end
        end else if (scan_res.found) begin
          wcmd.kind = CMD_WRITE;
          res_slot  = SLOT_FLD_W'(scan_res.idx);
          res_load  = wcmd.load;
        end else if (scan_res.free_found) begin
          wcmd.kind = CMD_WRITE;
          wcmd.idx  = scan_res.free_idx;
          wcmd.load = LOAD_W'(1);
          res_slot  = SLOT_FLD_W'(scan_res.free_idx);
          res_load  = LOAD_W'(1);
        end else begin
          res_status = STS_FULL;
        end
      end
      OP_RELEASE: begin
        res_slot = slot_q;
        wcmd.idx = ctl.tgt;
        if (!slot_ok || !scan_res.tgt_active) begin
          res_status = STS_UNKNOWN;
        end else if (scan_res.tgt_load == '0) begin
          res_status = STS_ZERO;
        end else if (mode == MODE_GROW && rel_load == '0 &&
                     scan_res.cnt > CNT_W'(1)) begin
          wcmd.kind   = CMD_WRITE;
          wcmd.load   = '0;
          wcmd.active = 1'b0;
          res_status  = STS_RETIRED;
        end else begin
          wcmd.kind = CMD_WRITE;
          wcmd.load = rel_load;
          res_load  = rel_load;
        end
      end
      OP_CLEAR: begin
        wcmd.kind = CMD_CLEAR;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      pool_ready <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (state == ST_BUILD) begin
        pool_ready <= 1'b1;
      end
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_q   <= op_t'(req.op);
      slot_q <= req.slot;
    end
    if (fire) begin
      rsp_slot   <= res_slot;
      rsp_status <= res_status;
      rsp_load   <= res_load;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    fire       = 1'b0;
    cmd        = wcmd;
    cmd.kind   = CMD_NONE;
    case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (req.valid) begin
          state_next = pool_ready ? ST_SCAN : ST_BUILD;
        end
      end
      ST_BUILD: begin
        cmd.kind   = CMD_BUILD;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cnt_next = cnt + SLOT_W'(1);
        if (cnt == SLOT_W'(MAX_SLOTS - 1)) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!rsp_valid || rsp.ready) begin
          fire       = 1'b1;
          cmd.kind   = wcmd.kind;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `WLB_ASSERT_IMP(a_write_only_on_decide, cmd.kind == CMD_WRITE, state == ST_DECIDE && fire)
  `WLB_ASSERT_NXT(a_accept_starts_work, req.valid && req.ready, state == ST_BUILD || state == ST_SCAN)
  `WLB_ASSERT_NXT(a_pool_stays_ready, pool_ready, pool_ready)
  `WLB_ASSERT_IMP(a_grant_has_load, fire && op_q == OP_ACQUIRE && res_status == STS_OK, res_load != '0)

endmodule

@@ rtl/worker_load_balancer_core.sv @@
// Top level of the worker load balancer: APB registers, the slot cell chain
// and the sequencer. Depends on wlb_pkg, wlb_if, wlb_cell and wlb_ctrl.
//
//  channel  dir  handshake            payload
//  req      in   valid/ready          op[1:0], slot[3:0]
//  rsp      out  valid/ready          granted_slot[3:0], status[2:0], load[15:0]
//  apb      in   psel/penable/pready  paddr[2:0], pwdata, prdata (mode @0, limit @4)
//
// A request is decided once the scan wave, crossing the chain one cell a cycle,
// has passed every slot; no new request is taken until then. The first request
// after reset also passes through a build state that builds the pool first.
// Reset clears the pool; it is rebuilt from mode and limit on the first request.
// A finished result waits in the output register; the next request is taken
// meanwhile, and its write-back waits until the previous result is taken.
module worker_load_balancer_core (
  input  logic                        clk,
  input  logic                        rst,
  wlb_req_if.sink                     req,
  wlb_rsp_if.source                   rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wlb_pkg::ADDR_W-1:0]  paddr,
  input  logic [wlb_pkg::DATA_W-1:0]  pwdata,
  output logic [wlb_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import wlb_pkg::*;

  logic               mode;
  logic [LIMIT_W-1:0] limit;
  ctl_t               ctl;
  cmd_t               cmd;
  scan_t              chain [MAX_SLOTS+1];

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_FIXED;
      limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_MODE:  mode  <= pwdata[0];
        REG_LIMIT: limit <= pwdata[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MODE:  prdata = DATA_W'(mode);
      REG_LIMIT: prdata = DATA_W'(limit);
      default:   prdata = '0;
    endcase
  end

  assign chain[0] = '0;

  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
    wlb_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (SLOT_W'(g)),
      .ctl      (ctl),
      .cmd      (cmd),
      .scan_in  (chain[g]),
      .scan_out (chain[g+1])
    );
  end

  wlb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .mode     (mode),
    .limit    (limit),
    .req      (req),
    .rsp      (rsp),
    .scan_res (chain[MAX_SLOTS]),
    .ctl      (ctl),
    .cmd      (cmd)
  );

endmodule
